// ===== rtl/ftc_pkg.sv =====
// Shared types and constants for the FAT type classifier.
// No dependencies.
package ftc_pkg;

   localparam int DvdWidth = 21;   // 32 * root_entries fits 21 bits
   localparam int RemWidth = 16;

   // clusters <= 4085 <=> data < 4086 * spc (for spc > 0)
   localparam logic [23:0] Fat12Bound = 24'd4086;
   localparam logic [23:0] Fat16Bound = 24'd65526;
   localparam logic [23:0] Fat32Min   = 24'd65526;

   typedef enum logic [1:0] {
      KIND_FAT12   = 2'd0,
      KIND_FAT16   = 2'd1,
      KIND_FAT32   = 2'd2,
      KIND_INVALID = 2'd3
   } ftc_kind_type;

   typedef struct packed {
      logic                layout32;
      logic                bad;
      logic [31:0]         total;
      logic [40:0]         base;
      logic [7:0]          spc;
      logic [15:0]         bps;
      logic [RemWidth-1:0] rem;
      logic [DvdWidth-1:0] dvd;
      logic [DvdWidth-1:0] quo;
   } ftc_item_type;

endpackage

// ===== rtl/fat_type_classifier_unit.sv =====
// FAT type classifier top level: front stage, division cell chain, classifier.
// Depends on ftc_pkg, ftc_div_cell, ftc_classify.
//
// Usage:
//   req_* carries one boot-sector parameter set per transaction; rsp_fat_kind
//   returns 0 FAT12, 1 FAT16, 2 FAT32, 3 invalid, one result per request,
//   in order.
//   The pipeline has one front stage (FAT size times copies), 21
//   division cells that each resolve one quotient bit of the root directory
//   sector count, and the classifier output register.
//   Throughput is one transaction per cycle while no result is held by rsp_stall.
//   When rsp_stall holds a valid result, the whole chain freezes and
//   req_stall is raised until the result is taken.
//   Synchronous reset empties the chain; no result is pending afterwards.
module fat_type_classifier_unit
   import ftc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_fat_size16,
   input  logic [31:0] req_fat_size32,
   input  logic [7:0]  req_fat_copies,
   input  logic [15:0] req_reserved_sectors,
   input  logic [15:0] req_root_entries,
   input  logic [15:0] req_bytes_per_sector,
   input  logic [7:0]  req_sectors_per_cluster,
   input  logic [15:0] req_total_sectors16,
   input  logic [31:0] req_total_sectors32,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_fat_kind
);
   logic         en;
   logic         front_valid_ff;
   ftc_item_type front_ff, front_in;
   logic [31:0]  fsz;
   logic [39:0]  prod;
   logic         l32;

   logic         cell_valid [DvdWidth+1];
   ftc_item_type cell_item  [DvdWidth+1];

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_comb begin
      l32  = (req_fat_size16 == 16'd0);
      fsz  = l32 ? req_fat_size32 : {16'd0, req_fat_size16};
      prod = fsz * {24'd0, req_fat_copies};
      front_in.layout32 = l32;
      front_in.bad = l32 ? (req_root_entries != 16'd0 || req_total_sectors16 != 16'd0
                            || req_sectors_per_cluster == 8'd0)
                         : (req_bytes_per_sector == 16'd0 || req_sectors_per_cluster == 8'd0);
      front_in.total = (!l32 && req_total_sectors16 != 16'd0)
                       ? {16'd0, req_total_sectors16} : req_total_sectors32;
      front_in.base = {25'd0, req_reserved_sectors} + {1'b0, prod};
      front_in.spc  = req_sectors_per_cluster;
      // nonzero divisor keeps the quotient at zero for the FAT32 layout
      front_in.bps  = l32 ? 16'd1 : req_bytes_per_sector;
      front_in.rem  = '0;
      // FAT32 layout has no root directory region
      front_in.dvd  = l32 ? '0 : {req_root_entries, 5'd0};
      front_in.quo  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (en) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         front_ff <= front_in;
      end
   end

   assign cell_valid[0] = front_valid_ff;
   assign cell_item[0]  = front_ff;

   for (genvar i = 0; i < DvdWidth; i++) begin : g_cell
      ftc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cell_valid[i]),
         .in_item   (cell_item[i]),
         .out_valid (cell_valid[i+1]),
         .out_item  (cell_item[i+1])
      );
   end

   ftc_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cell_valid[DvdWidth]),
      .in_item   (cell_item[DvdWidth]),
      .out_valid (rsp_valid),
      .out_kind  (rsp_fat_kind)
   );

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   a_chain_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(cell_valid[DvdWidth]) && $stable(front_valid_ff))
      else $error("chain moved while output stalled");

   a_chain_drain: assert property (@(posedge clock) disable iff (reset)
      (cell_valid[DvdWidth] && en) |=> rsp_valid)
      else $error("item lost between last cell and output");

   a_front_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> front_valid_ff)
      else $error("accepted transaction not captured");
endmodule

// ===== rtl/ftc_div_cell.sv =====
// One restoring-division cell: produces one quotient bit of the root-dir size.
// Depends on ftc_pkg.
module ftc_div_cell
   import ftc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  ftc_item_type in_item,
   output logic         out_valid,
   output ftc_item_type out_item
);
   logic         valid_ff;
   ftc_item_type item_ff, item_in;
   logic [RemWidth:0] part, diff;
   logic         ge;

   always_comb begin
      part    = {in_item.rem, in_item.dvd[DvdWidth-1]};
      diff    = part - {1'b0, in_item.bps};
      ge      = part >= {1'b0, in_item.bps};
      item_in = in_item;
      item_in.rem = ge ? diff[RemWidth-1:0] : part[RemWidth-1:0];
      item_in.quo = {in_item.quo[DvdWidth-2:0], ge};
      item_in.dvd = {in_item.dvd[DvdWidth-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

// ===== rtl/ftc_classify.sv =====
// Final stage: data sector count against cluster thresholds, output register.
// Depends on ftc_pkg.
module ftc_classify
   import ftc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  ftc_item_type in_item,
   output logic         out_valid,
   output logic [1:0]   out_kind
);
   logic               valid_ff;
   ftc_kind_type       kind_ff, kind_in;
   logic [21:0]        rootsec;
   logic [41:0]        start;
   logic signed [41:0] data;
   logic [23:0]        t12, t16, t32;

   always_comb begin
      rootsec = {1'b0, in_item.quo} + {21'd0, |in_item.rem};
      start   = {1'b0, in_item.base} + {20'd0, rootsec};
      data    = $signed({10'd0, in_item.total}) - $signed(start);
      t12     = {16'd0, in_item.spc} * Fat12Bound;
      t16     = {16'd0, in_item.spc} * Fat16Bound;
      t32     = {16'd0, in_item.spc} * Fat32Min;
      priority if (in_item.bad) begin
         kind_in = KIND_INVALID;
      end else if (in_item.layout32) begin
         kind_in = (data >= $signed({18'd0, t32})) ? KIND_FAT32 : KIND_INVALID;
      end else if (data < $signed({18'd0, t12})) begin
         kind_in = KIND_FAT12;
      end else if (data < $signed({18'd0, t16})) begin
         kind_in = KIND_FAT16;
      end else begin
         kind_in = KIND_INVALID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff <= kind_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
endmodule
